FILE: hw/rtl/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared widths, types and helpers for the radix-m digit sum block.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  localparam int OPERAND_W       = 31;
  localparam int SUM_W           = 32;
  localparam int RADIX_W         = 4;
  localparam int DIGIT_W         = 4;
  localparam int DIV_BITS_PER_CY = 4;
  localparam int DIV_CYCLES      = SUM_W / DIV_BITS_PER_CY;
  localparam int DIV_CNT_W       = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(9);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);

  typedef struct packed {
    logic busy;
    logic done;
  } rmsd_div_stat_t;

  // Bases outside two to nine are pulled to the nearest legal base.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] raw);
    logic [RADIX_W-1:0] res;
    if (raw < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (raw > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/rmsd_in_if.sv
// ----------------------------------------------------------------------------
// rmsd_in_if
// Input channel: one word carries the two binary addends.
// ----------------------------------------------------------------------------
interface rmsd_in_if;
  import rmsd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OPERAND_W-1:0] operand_a;
  logic [OPERAND_W-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);

endinterface

FILE: hw/rtl/rmsd_out_if.sv
// ----------------------------------------------------------------------------
// rmsd_out_if
// Result channel: one word carries one digit and the end-of-run flag.
// ----------------------------------------------------------------------------
interface rmsd_out_if;
  import rmsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);

endinterface

FILE: hw/rtl/rmsd_div.sv
// ----------------------------------------------------------------------------
// rmsd_div
// Digit-serial divider: divides a 32-bit value by the radix, four dividend
// bits per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
module rmsd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rmsd_pkg::SUM_W-1:0]    dividend,
  input  logic [rmsd_pkg::RADIX_W-1:0]  radix,
  output rmsd_pkg::rmsd_div_stat_t      stat,
  output logic [rmsd_pkg::SUM_W-1:0]    quotient,
  output logic [rmsd_pkg::RADIX_W-1:0]  remainder
);
  import rmsd_pkg::*;

  logic [SUM_W-1:0]     shreg_r, shreg_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cyc_r;
  logic                 busy_r;
  logic                 done_r;

  // The dividend shifts out at the top while quotient bits shift in at the
  // bottom, so the same register ends up holding the quotient.
  always_comb begin
    logic [RADIX_W:0]   trial;
    logic [SUM_W-1:0]   q;
    logic [RADIX_W-1:0] r;
    q = shreg_r;
    r = rem_r;
    for (int i = 0; i < DIV_BITS_PER_CY; i++) begin
      trial = {r, q[SUM_W-1]};
      q     = {q[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, radix}) begin
        trial = trial - {1'b0, radix};
        q[0]  = 1'b1;
      end
      r = trial[RADIX_W-1:0];
    end
    shreg_nxt = q;
    rem_nxt   = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cyc_r  <= '0;
      end else if (busy_r) begin
        cyc_r <= cyc_r + DIV_CNT_W'(1);
        if (cyc_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      shreg_r <= dividend;
      rem_r   <= '0;
    end else if (busy_r) begin
      shreg_r <= shreg_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = shreg_r;
  assign remainder = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cyc_r != DIV_CNT_W'(DIV_CYCLES - 1)) |=> busy_r)
    else $error("divider dropped busy early");

endmodule

FILE: hw/rtl/rmsd_digit_mem.sv
// ----------------------------------------------------------------------------
// rmsd_digit_mem
// Digit store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module rmsd_digit_mem #(
  parameter  int DEPTH  = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [rmsd_pkg::DIGIT_W-1:0] wdata,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [rmsd_pkg::DIGIT_W-1:0] rdata
);
  import rmsd_pkg::*;

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/radix_m_sum_digits.sv
// ----------------------------------------------------------------------------
// radix_m_sum_digits
// Adds two 31-bit binary operands and returns the sum as base-m digits.
// ----------------------------------------------------------------------------
// One input word holds two non-negative addends. Their 32-bit sum is turned
// into digits of the base held in the radix register (bases below two act as
// two, above nine as nine), and the digits leave as one output word each,
// most significant first, with last_digit set on the final one. A zero sum
// gives the single digit 0. At most DIGIT_SLOTS digits are produced; if the
// sum needs more, only the DIGIT_SLOTS least significant digits are sent.
// The block works on one word at a time: in_chan.ready is high only while it
// is idle. Each digit comes from one pass of a shared serial divider that
// handles four dividend bits per cycle: the divider is started, works
// through the dividend, and its remainder is written to the digit store as
// the digit when it signals done. Each digit is then read back from the
// digit store in ST_WAIT and presented in ST_SHOW. Cycles the sink holds
// ready low stretch a run. The radix register is written through cfg_we
// and cfg_data and should only change while the block is idle.
// ----------------------------------------------------------------------------
module radix_m_sum_digits #(
  parameter int DIGIT_SLOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rmsd_pkg::RADIX_W-1:0] cfg_data,
  rmsd_in_if.sink                      in_chan,
  rmsd_out_if.source                   out_chan
);
  import rmsd_pkg::*;

  localparam int IDX_W = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT,
    ST_SHOW
  } state_t;

  state_t             state_r;
  logic [RADIX_W-1:0] radix_r;
  logic [SUM_W-1:0]   remaining_value_r;
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               div_start_r;

  logic [SUM_W-1:0]   sum;
  logic               in_acc;
  logic               out_acc;
  rmsd_div_stat_t     div_stat;
  logic [SUM_W-1:0]   div_quot;
  logic [RADIX_W-1:0] div_rem;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [DIGIT_W-1:0] mem_wdata;
  logic [DIGIT_W-1:0] mem_rdata;

  // The sum of two 31-bit operands always fits in 32 bits.
  assign sum     = {1'b0, in_chan.operand_a} + {1'b0, in_chan.operand_b};
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = (state_r == ST_SHOW);
  assign out_chan.digit      = mem_rdata;
  assign out_chan.last_digit = (rd_idx_r == '0);

  // Digits are stored least significant first; a zero sum stores its single
  // zero digit straight from the idle state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_wdata = div_rem;
    if (in_acc && sum == '0) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '0;
    end else if (state_r == ST_DIV && div_stat.done) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_data;
    end
  end

  // Control sequence: accept a word, run the divider once per digit until the
  // quotient reaches zero or the store is full, then read the digits back
  // from the top. The store's read data is registered, so every digit passes
  // through ST_WAIT before it is shown in ST_SHOW.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      remaining_value_r <= '0;
      count_r           <= '0;
      rd_idx_r          <= '0;
      div_start_r       <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            remaining_value_r <= sum;
            if (sum == '0) begin
              count_r  <= CNT_W'(1);
              rd_idx_r <= '0;
              state_r  <= ST_WAIT;
            end else begin
              count_r     <= '0;
              div_start_r <= 1'b1;
              state_r     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            remaining_value_r <= div_quot;
            count_r           <= count_r + CNT_W'(1);
            if (div_quot == '0 || count_r == CNT_W'(DIGIT_SLOTS - 1)) begin
              rd_idx_r <= count_r[IDX_W-1:0];
              state_r  <= ST_WAIT;
            end else begin
              div_start_r <= 1'b1;
            end
          end
        end
        ST_WAIT: begin
          state_r <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_acc) begin
            if (rd_idx_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              rd_idx_r <= rd_idx_r - IDX_W'(1);
              state_r  <= ST_WAIT;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  rmsd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (remaining_value_r),
    .radix     (eff_radix(radix_r)),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rmsd_digit_mem #(
    .DEPTH (DIGIT_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx_r),
    .rdata (mem_rdata)
  );

  // Input and output never overlap: a new word waits for the last digit.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !in_chan.ready)
    else $error("input accepted while digits are pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DIGIT_SLOTS))
    else $error("digit count exceeds store depth");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_chan.last_digit) |=> in_chan.ready)
    else $error("block not idle after the final digit");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the conversion state");

endmodule
